@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the q-axis current block.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define FOC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Plain invariant that must hold at every edge.
`define FOC_ASSERT_ALWAYS(label, expr, msg) \
	`FOC_ASSERT(label, expr, msg)

`endif

@@ hw/rtl/foc_iq_pkg.sv @@
// Package for the q-axis current block: sizes, constants, microcode and CORDIC tables.
// Used by the channel interfaces, the CORDIC unit and the top level; no dependencies.
package foc_iq_pkg;

	// Build-time sizes
	localparam int CAL_SAMPLES   = 1000;
	localparam int ANGLE_BITS    = 12;
	localparam int ADC_BITS      = 12;

	// Field widths on the channels
	localparam int ADC_FIELD_W   = 12;
	localparam int ANGLE_FIELD_W = 12;
	localparam int SCALE_W       = 24;
	localparam int IQ_W          = 24;

	// Stored state
	localparam int SUM_W = 22;
	localparam int CNT_W = 10;
	localparam int OFF_W = 20;
	localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(65536);

	// Fixed point
	localparam int FRAC_W      = 8;
	localparam int PROD_SHIFT  = 16;
	localparam int INV_SQRT3   = 37837;
	localparam int IQ_MAX      = 8388607;
	localparam int IQ_MIN      = -8388608;
	localparam int D_W = ((ADC_BITS + FRAC_W > OFF_W) ? ADC_BITS + FRAC_W : OFF_W) + 1;
	localparam int I_W = D_W + SCALE_W - PROD_SHIFT;
	localparam int T_W = I_W + 2;
	localparam int N_W = SUM_W + FRAC_W;

	// Offset = floor(n / CAL_SAMPLES) through a reciprocal and one correction
	localparam int DIV_SHIFT = N_W + $clog2(CAL_SAMPLES);
	localparam longint DIV_MULT = (longint'(1) << DIV_SHIFT) / CAL_SAMPLES;

	// Shared multiplier
	localparam int MUL_W = (T_W > 33) ? T_W : 33;
	localparam int P_W   = 2 * MUL_W;

	// CORDIC
	localparam int CORDIC_GAIN    = 39797;
	localparam int CORDIC_STEPS   = 14;
	localparam int CORDIC_PER_CYC = 2;
	localparam int CORDIC_CYC     = CORDIC_STEPS / CORDIC_PER_CYC;
	localparam int CIT_W          = $clog2(CORDIC_CYC);
	localparam int STEP_W         = $clog2(CORDIC_STEPS);
	localparam int ATAN_W         = 14;
	localparam int C_W            = 20;
	localparam int Z_W            = 18;

	typedef struct packed {
		logic                  busy;
		logic signed [C_W-1:0] sin_v;
		logic signed [C_W-1:0] cos_v;
	} cordic_res_t;

	// Microcode fields
	localparam int MOP_W = 3;
	localparam int ACT_W = 4;
	localparam int JMP_W = 2;
	localparam int PC_W  = 4;

	// Multiplier operand pairs
	localparam logic [MOP_W-1:0] MOP_NONE = 3'd0;
	localparam logic [MOP_W-1:0] MOP_DA   = 3'd1;
	localparam logic [MOP_W-1:0] MOP_DB   = 3'd2;
	localparam logic [MOP_W-1:0] MOP_T    = 3'd3;
	localparam logic [MOP_W-1:0] MOP_BC   = 3'd4;
	localparam logic [MOP_W-1:0] MOP_AS   = 3'd5;
	localparam logic [MOP_W-1:0] MOP_CA   = 3'd6;
	localparam logic [MOP_W-1:0] MOP_CB   = 3'd7;

	// Register load actions
	localparam logic [ACT_W-1:0] ACT_NONE   = 4'd0;
	localparam logic [ACT_W-1:0] ACT_IA     = 4'd1;
	localparam logic [ACT_W-1:0] ACT_T      = 4'd2;
	localparam logic [ACT_W-1:0] ACT_BETA   = 4'd3;
	localparam logic [ACT_W-1:0] ACT_ACC    = 4'd4;
	localparam logic [ACT_W-1:0] ACT_FIN    = 4'd5;
	localparam logic [ACT_W-1:0] ACT_CALSUM = 4'd6;
	localparam logic [ACT_W-1:0] ACT_OFFA   = 4'd7;
	localparam logic [ACT_W-1:0] ACT_OFFB   = 4'd8;
	localparam logic [ACT_W-1:0] ACT_CEND   = 4'd9;

	// Jump conditions
	localparam logic [JMP_W-1:0] J_NEXT  = 2'd0;
	localparam logic [JMP_W-1:0] J_CORD  = 2'd1;
	localparam logic [JMP_W-1:0] J_NFULL = 2'd2;

	// Program addresses
	localparam logic [PC_W-1:0] UC_NULL = 4'd0;
	localparam logic [PC_W-1:0] UC_MDA  = 4'd1;
	localparam logic [PC_W-1:0] UC_MDB  = 4'd2;
	localparam logic [PC_W-1:0] UC_SUM  = 4'd3;
	localparam logic [PC_W-1:0] UC_MT   = 4'd4;
	localparam logic [PC_W-1:0] UC_WAIT = 4'd5;
	localparam logic [PC_W-1:0] UC_MBC  = 4'd6;
	localparam logic [PC_W-1:0] UC_MAS  = 4'd7;
	localparam logic [PC_W-1:0] UC_FIN  = 4'd8;
	localparam logic [PC_W-1:0] UC_CACC = 4'd9;
	localparam logic [PC_W-1:0] UC_CMA  = 4'd10;
	localparam logic [PC_W-1:0] UC_CMB  = 4'd11;
	localparam logic [PC_W-1:0] UC_COFF = 4'd12;
	localparam logic [PC_W-1:0] UC_CEND = 4'd13;

	typedef struct packed {
		logic [MOP_W-1:0] mop;
		logic [ACT_W-1:0] act;
		logic [JMP_W-1:0] jmp;
		logic [PC_W-1:0]  tgt;
		logic             last;
	} uc_word_t;

	// Control store
	function automatic uc_word_t uc_rom(input logic [PC_W-1:0] addr);
		uc_word_t w;
		unique case (addr)
			UC_MDA:  w = '{MOP_DA,   ACT_NONE,   J_NEXT,  UC_NULL, 1'b0};
			UC_MDB:  w = '{MOP_DB,   ACT_IA,     J_NEXT,  UC_NULL, 1'b0};
			UC_SUM:  w = '{MOP_NONE, ACT_T,      J_NEXT,  UC_NULL, 1'b0};
			UC_MT:   w = '{MOP_T,    ACT_NONE,   J_NEXT,  UC_NULL, 1'b0};
			UC_WAIT: w = '{MOP_NONE, ACT_BETA,   J_CORD,  UC_WAIT, 1'b0};
			UC_MBC:  w = '{MOP_BC,   ACT_NONE,   J_NEXT,  UC_NULL, 1'b0};
			UC_MAS:  w = '{MOP_AS,   ACT_ACC,    J_NEXT,  UC_NULL, 1'b0};
			UC_FIN:  w = '{MOP_NONE, ACT_FIN,    J_NEXT,  UC_NULL, 1'b1};
			UC_CACC: w = '{MOP_NONE, ACT_CALSUM, J_NFULL, UC_CEND, 1'b0};
			UC_CMA:  w = '{MOP_CA,   ACT_NONE,   J_NEXT,  UC_NULL, 1'b0};
			UC_CMB:  w = '{MOP_CB,   ACT_OFFA,   J_NEXT,  UC_NULL, 1'b0};
			UC_COFF: w = '{MOP_NONE, ACT_OFFB,   J_NEXT,  UC_NULL, 1'b0};
			UC_CEND: w = '{MOP_NONE, ACT_CEND,   J_NEXT,  UC_NULL, 1'b1};
			default: w = '{MOP_NONE, ACT_NONE,   J_NEXT,  UC_NULL, 1'b1};
		endcase
		return w;
	endfunction

	// atan(2^-i) in 2^-16 turn units
	function automatic logic [ATAN_W-1:0] cordic_atan(input logic [STEP_W-1:0] i);
		logic [ATAN_W-1:0] a;
		unique case (i)
			4'd0:    a = 14'd8192;
			4'd1:    a = 14'd4836;
			4'd2:    a = 14'd2555;
			4'd3:    a = 14'd1297;
			4'd4:    a = 14'd651;
			4'd5:    a = 14'd326;
			4'd6:    a = 14'd163;
			4'd7:    a = 14'd81;
			4'd8:    a = 14'd41;
			4'd9:    a = 14'd20;
			4'd10:   a = 14'd10;
			4'd11:   a = 14'd5;
			4'd12:   a = 14'd3;
			4'd13:   a = 14'd1;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

@@ hw/rtl/foc_iq_if.sv @@
// Valid/ready channel interfaces: sample input, result output and scale write.
// Depends on foc_iq_pkg for field widths.
interface foc_iq_in_if;
	import foc_iq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic [ADC_FIELD_W-1:0]   adc_a;
	logic [ADC_FIELD_W-1:0]   adc_b;
	logic [ANGLE_FIELD_W-1:0] angle;
	modport source (output valid, command, adc_a, adc_b, angle, input ready);
	modport sink (input valid, command, adc_a, adc_b, angle, output ready);
endinterface

interface foc_iq_out_if;
	import foc_iq_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [IQ_W-1:0] iq;
	logic                   calibrated;
	modport source (output valid, iq, calibrated, input ready);
	modport sink (input valid, iq, calibrated, output ready);
endinterface

interface foc_iq_cfg_if;
	import foc_iq_pkg::*;
	logic               valid;
	logic               ready;
	logic [SCALE_W-1:0] current_scale;
	modport source (output valid, current_scale, input ready);
	modport sink (input valid, current_scale, output ready);
endinterface

@@ hw/rtl/foc_iq_cordic.sv @@
// Iterative CORDIC giving sin and cos (Q1.16) of an electrical angle, two steps a cycle.
// Depends on foc_iq_pkg for sizes, the gain and the arctangent table.
module foc_iq_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [foc_iq_pkg::ANGLE_BITS-1:0] angle,
	output foc_iq_pkg::cordic_res_t           res
);
	import foc_iq_pkg::*;

	localparam logic signed [Z_W-1:0] QUARTER = Z_W'(16384);
	localparam logic signed [Z_W-1:0] HALF    = Z_W'(32768);

	logic                  busy_q;
	logic [CIT_W-1:0]      it_q;
	logic                  fin;
	logic signed [C_W-1:0] x_q, y_q;
	logic signed [Z_W-1:0] z_q;
	logic                  flip_q;
	logic [15:0]           a16;
	logic signed [Z_W-1:0] z_raw, z_init;
	logic                  flip_init;
	logic signed [C_W-1:0] xs [CORDIC_PER_CYC+1];
	logic signed [C_W-1:0] ys [CORDIC_PER_CYC+1];
	logic signed [Z_W-1:0] zs [CORDIC_PER_CYC+1];
	logic [STEP_W-1:0]     idx [CORDIC_PER_CYC];

	// Widen to a 2^16 turn and fold into [-90, 90] degrees
	always_comb begin
		a16 = 16'(angle) << (16 - ANGLE_BITS);
		z_raw = Z_W'($signed(a16));
		flip_init = 1'b0;
		z_init = z_raw;
		if (z_raw > QUARTER) begin
			z_init = z_raw - HALF;
			flip_init = 1'b1;
		end else if (z_raw < -QUARTER) begin
			z_init = z_raw + HALF;
			flip_init = 1'b1;
		end
	end

	always_comb begin
		xs[0] = x_q;
		ys[0] = y_q;
		zs[0] = z_q;
		for (int j = 0; j < CORDIC_PER_CYC; j++) begin
			idx[j] = STEP_W'(int'(it_q) * CORDIC_PER_CYC + j);
			if (zs[j] >= 0) begin
				xs[j+1] = xs[j] - (ys[j] >>> idx[j]);
				ys[j+1] = ys[j] + (xs[j] >>> idx[j]);
				zs[j+1] = zs[j] - $signed(Z_W'(cordic_atan(idx[j])));
			end else begin
				xs[j+1] = xs[j] + (ys[j] >>> idx[j]);
				ys[j+1] = ys[j] - (xs[j] >>> idx[j]);
				zs[j+1] = zs[j] + $signed(Z_W'(cordic_atan(idx[j])));
			end
		end
	end

	assign fin = (it_q == CIT_W'(CORDIC_CYC - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			it_q   <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			it_q   <= '0;
		end else if (busy_q) begin
			if (fin) begin
				busy_q <= 1'b0;
			end else begin
				it_q <= it_q + CIT_W'(1);
			end
		end
	end

	// Undo the half-turn fold on the last pass
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= C_W'(CORDIC_GAIN);
			y_q    <= '0;
			z_q    <= z_init;
			flip_q <= flip_init;
		end else if (busy_q) begin
			x_q <= (fin && flip_q) ? -xs[CORDIC_PER_CYC] : xs[CORDIC_PER_CYC];
			y_q <= (fin && flip_q) ? -ys[CORDIC_PER_CYC] : ys[CORDIC_PER_CYC];
			z_q <= zs[CORDIC_PER_CYC];
		end
	end

	assign res.busy  = busy_q;
	assign res.sin_v = y_q;
	assign res.cos_v = x_q;

endmodule

@@ hw/rtl/foc_current_to_iq_unit.sv @@
// Top level of the q-axis current block: microcoded datapath with one shared multiplier.
// Depends on foc_iq_pkg, the channel interfaces, foc_iq_cordic and assert_macros.svh.
//
// Usage
//   sample : command, adc_a, adc_b, angle. command 0 adds a zero-current calibration
//            sample; command 1 measures and returns the q-axis current.
//   result : iq (signed Q15.8 A, saturated; zero for calibration) and calibrated.
//            Exactly one result per sample transfer, in order.
//   cfg    : write of current_scale (unsigned Q8.16 A per count); always ready.
//            Write it only while the block is idle.
// Timing
//   Measure: the shared multiplier scales ia and ib, then t into beta, then beta*cos and
//   alpha*sin; the CORDIC (two rotations a cycle) runs alongside, and beta*cos waits for it.
//   Calibration: accumulate the sample, or, on the sample that closes a run, also
//   reload both offsets through the reciprocal multiply.
//   sample.ready is low until the result loads, so one sample is in progress at a time.
// Reset clears the sums, count, offsets and calibrated flag and loads a scale of 1.0.
// A stalled receiver holds the result register; the next sample may still transfer,
// and its final step waits until the held result has gone.
module foc_current_to_iq_unit (
	input logic          clk,
	input logic          arst_n,
	foc_iq_in_if.sink    sample,
	foc_iq_out_if.source result,
	foc_iq_cfg_if.sink   cfg
);
	import foc_iq_pkg::*;

	localparam logic signed [P_W-1:0] IQ_HI = P_W'(IQ_MAX);
	localparam logic signed [P_W-1:0] IQ_LO = P_W'(IQ_MIN);

	// Sequencer
	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	uc_word_t        uc;
	logic            stall, run, take_jump, in_acc;

	// Configuration and calibration state
	logic [SCALE_W-1:0] scale_q;
	logic [SUM_W-1:0]   sum_a_q, sum_b_q;
	logic [CNT_W-1:0]   cnt_q, cnt_nxt;
	logic               cnt_full;
	logic [OFF_W-1:0]   off_a_q, off_b_q;
	logic               cal_done_q;

	// Datapath
	logic [ADC_BITS-1:0]   adc_a_q, adc_b_q;
	logic signed [D_W-1:0] d_a, d_b;
	logic [N_W-1:0]        n_a, n_b;
	logic signed [MUL_W-1:0] ma, mb;
	logic signed [P_W-1:0] prod, p_q, p_sh, acc_q, diff, dsh;
	logic signed [I_W-1:0] ia_q, ib;
	logic signed [T_W-1:0] t_nxt, t_q, beta_q;
	logic [IQ_W-1:0]       iq_sat;

	// Result register
	logic            out_vld_q;
	logic [IQ_W-1:0] iq_q;
	logic            cal_out_q;

	cordic_res_t cres;

	// Finish floor(n / CAL_SAMPLES) from the reciprocal product: bump by one if short
	function automatic logic [OFF_W-1:0] div_fix(input logic [P_W-1:0] p,
			input logic [N_W-1:0] n);
		logic [N_W-1:0] q0, back, r;
		q0 = N_W'(p >> DIV_SHIFT);
		back = q0 * N_W'(CAL_SAMPLES);
		r = n - back;
		if (r >= N_W'(CAL_SAMPLES)) begin
			return OFF_W'(q0 + N_W'(1));
		end
		return OFF_W'(q0);
	endfunction

	assign in_acc       = sample.valid && sample.ready;
	assign sample.ready = !busy_q;
	assign cfg.ready    = 1'b1;

	assign uc    = uc_rom(pc_q);
	// hold the final step while the previous result still waits
	assign stall = uc.last && out_vld_q && !result.ready;
	assign run   = busy_q && !stall;

	assign cnt_nxt  = cnt_q + CNT_W'(1);
	assign cnt_full = (cnt_nxt >= CNT_W'(CAL_SAMPLES));

	always_comb begin
		unique case (uc.jmp)
			J_CORD:  take_jump = cres.busy;
			J_NFULL: take_jump = !cnt_full;
			default: take_jump = 1'b0;
		endcase
	end

	// Offset-corrected samples in Q.8 counts, and the scaled sums for the offsets
	assign d_a = D_W'({adc_a_q, {FRAC_W{1'b0}}}) - D_W'(off_a_q);
	assign d_b = D_W'({adc_b_q, {FRAC_W{1'b0}}}) - D_W'(off_b_q);
	assign n_a = {sum_a_q, {FRAC_W{1'b0}}};
	assign n_b = {sum_b_q, {FRAC_W{1'b0}}};

	// Shared multiplier operand select
	always_comb begin
		unique case (uc.mop)
			MOP_DA: begin
				ma = MUL_W'(d_a);
				mb = $signed(MUL_W'(scale_q));
			end
			MOP_DB: begin
				ma = MUL_W'(d_b);
				mb = $signed(MUL_W'(scale_q));
			end
			MOP_T: begin
				ma = MUL_W'(t_q);
				mb = MUL_W'(INV_SQRT3);
			end
			MOP_BC: begin
				ma = MUL_W'(beta_q);
				mb = MUL_W'($signed(cres.cos_v));
			end
			MOP_AS: begin
				ma = MUL_W'(ia_q);
				mb = MUL_W'($signed(cres.sin_v));
			end
			MOP_CA: begin
				ma = $signed(MUL_W'(n_a));
				mb = MUL_W'(DIV_MULT);
			end
			MOP_CB: begin
				ma = $signed(MUL_W'(n_b));
				mb = MUL_W'(DIV_MULT);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign prod  = ma * mb;
	assign p_sh  = p_q >>> PROD_SHIFT;
	assign ib    = p_sh[I_W-1:0];
	// Clarke numerator: ia + 2*ib
	assign t_nxt = T_W'(ia_q) + (T_W'(ib) <<< 1);
	// Park: beta*cos - alpha*sin, then floor to Q.8 and saturate
	assign diff  = acc_q - p_q;
	assign dsh   = diff >>> PROD_SHIFT;

	always_comb begin
		priority if (dsh > IQ_HI) begin
			iq_sat = IQ_HI[IQ_W-1:0];
		end else if (dsh < IQ_LO) begin
			iq_sat = IQ_LO[IQ_W-1:0];
		end else begin
			iq_sat = dsh[IQ_W-1:0];
		end
	end

	// Control and calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pc_q       <= UC_NULL;
			out_vld_q  <= 1'b0;
			scale_q    <= SCALE_RESET;
			sum_a_q    <= '0;
			sum_b_q    <= '0;
			cnt_q      <= '0;
			off_a_q    <= '0;
			off_b_q    <= '0;
			cal_done_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				scale_q <= cfg.current_scale;
			end

			// load a new result on the final step, else drop it once transferred
			if (run && uc.last) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end

			if (!busy_q) begin
				if (in_acc) begin
					busy_q <= 1'b1;
					pc_q   <= sample.command ? UC_MDA : UC_CACC;
				end
			end else if (run) begin
				if (uc.last) begin
					busy_q <= 1'b0;
				end else if (take_jump) begin
					pc_q <= uc.tgt;
				end else begin
					pc_q <= pc_q + PC_W'(1);
				end
			end

			if (run) begin
				unique case (uc.act)
					ACT_CALSUM: begin
						sum_a_q <= sum_a_q + SUM_W'(adc_a_q);
						sum_b_q <= sum_b_q + SUM_W'(adc_b_q);
						cnt_q   <= cnt_nxt;
					end
					ACT_OFFA: begin
						off_a_q <= div_fix(p_q, n_a);
					end
					ACT_OFFB: begin
						off_b_q    <= div_fix(p_q, n_b);
						sum_a_q    <= '0;
						sum_b_q    <= '0;
						cnt_q      <= '0;
						cal_done_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			adc_a_q <= sample.adc_a[ADC_BITS-1:0];
			adc_b_q <= sample.adc_b[ADC_BITS-1:0];
		end
		if (run && uc.mop != MOP_NONE) begin
			p_q <= prod;
		end
		if (run) begin
			unique case (uc.act)
				ACT_IA:   ia_q   <= p_sh[I_W-1:0];
				ACT_T:    t_q    <= t_nxt;
				ACT_BETA: beta_q <= p_sh[T_W-1:0];
				ACT_ACC:  acc_q  <= p_q;
				ACT_FIN: begin
					iq_q      <= iq_sat;
					cal_out_q <= cal_done_q;
				end
				ACT_CEND: begin
					iq_q      <= '0;
					cal_out_q <= cal_done_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign result.valid      = out_vld_q;
	assign result.iq         = iq_q;
	assign result.calibrated = cal_out_q;

	// Sine and cosine run alongside the first multiplier steps
	foc_iq_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.angle  (sample.angle[ANGLE_BITS-1:0]),
		.res    (cres)
	);

`include "assert_macros.svh"

	`FOC_ASSERT(a_accept_busy, in_acc |=> busy_q, "transfer did not start the sequencer")
	`FOC_ASSERT(a_cordic_ready, (busy_q && pc_q == UC_MBC) |-> !cres.busy, "CORDIC still busy")
	`FOC_ASSERT_ALWAYS(a_cnt_idle, !busy_q |-> (cnt_q < CNT_W'(CAL_SAMPLES)), "count left full")
	`FOC_ASSERT(a_result_src, $rose(out_vld_q) |-> $past(uc.last), "result loaded off a final step")

endmodule

@@ sim/foc_current_to_iq_unit_test.sv @@
// Testbench for foc_current_to_iq_unit: directed and random samples, a scale write per phase.
// Depends on foc_iq_pkg and the channel interfaces; a scoreboard class predicts each result.
module foc_current_to_iq_unit_test;
	import foc_iq_pkg::*;

	localparam logic CMD_CALIBRATE = 1'b0;
	localparam logic CMD_MEASURE   = 1'b1;
	localparam int   REPORT_LIMIT  = 10;
	localparam int   PHASE_ITEMS   = 330;
	localparam int   PHASES        = 6;
	localparam int   DRAIN_CYCLES  = 16;
	localparam int   RUN_LIMIT     = 2000000;

	typedef struct packed {
		logic                     command;
		logic [ADC_FIELD_W-1:0]   adc_a;
		logic [ADC_FIELD_W-1:0]   adc_b;
		logic [ANGLE_FIELD_W-1:0] angle;
	} sample_t;

	typedef struct {
		logic signed [IQ_W-1:0] iq;
		logic                   calibrated;
	} iq_result_t;

	// Tracks offsets, sums and scale as the block should, and holds the q currents still due.
	class q_current_board;
		logic [SCALE_W-1:0] amps_per_count;
		logic [SUM_W-1:0]   raw_sum_a, raw_sum_b;
		logic [CNT_W-1:0]   sample_count;
		logic [OFF_W-1:0]   zero_a, zero_b;
		logic               offsets_valid;
		int                 atan_step[CORDIC_STEPS];
		iq_result_t         iq_due[$];
		int unsigned        mismatches;

		function new();
			amps_per_count = SCALE_RESET;
			raw_sum_a = '0;
			raw_sum_b = '0;
			sample_count = '0;
			zero_a = '0;
			zero_b = '0;
			offsets_valid = 1'b0;
			atan_step = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
			mismatches = 0;
		endfunction

		function int pending();
			return iq_due.size();
		endfunction

		// Phase current in Q.8 amperes; >>> on a signed longint floors.
		function longint phase_amps(logic [ADC_FIELD_W-1:0] adc, logic [OFF_W-1:0] zero);
			longint d;
			d = (longint'(adc & ((1 << ADC_BITS) - 1)) << FRAC_W) - longint'(zero);
			return (d * longint'(amps_per_count)) >>> PROD_SHIFT;
		endfunction

		function void accept_sample(sample_t s);
			longint     ia, ib, beta, x, y, dx, dy, q;
			int         z;
			bit         flip;
			iq_result_t r;
			q = 0;
			if (s.command == CMD_CALIBRATE) begin
				raw_sum_a = raw_sum_a + SUM_W'(s.adc_a & ((1 << ADC_BITS) - 1));
				raw_sum_b = raw_sum_b + SUM_W'(s.adc_b & ((1 << ADC_BITS) - 1));
				sample_count = sample_count + 1'b1;
				if (sample_count >= CAL_SAMPLES) begin
					zero_a = OFF_W'((longint'(raw_sum_a) << FRAC_W) / CAL_SAMPLES);
					zero_b = OFF_W'((longint'(raw_sum_b) << FRAC_W) / CAL_SAMPLES);
					raw_sum_a = '0;
					raw_sum_b = '0;
					sample_count = '0;
					offsets_valid = 1'b1;
				end
			end else begin
				ia = phase_amps(s.adc_a, zero_a);
				ib = phase_amps(s.adc_b, zero_b);
				beta = ((ia + 2 * ib) * INV_SQRT3) >>> PROD_SHIFT;
				// Widen the angle to a 16-bit turn, fold it into +-90 degrees, then rotate.
				z = (int'(s.angle) & ((1 << ANGLE_BITS) - 1)) << (16 - ANGLE_BITS);
				if (z >= 32768)
					z = z - 65536;
				flip = 1'b0;
				if (z > 16384) begin
					z = z - 32768;
					flip = 1'b1;
				end else if (z < -16384) begin
					z = z + 32768;
					flip = 1'b1;
				end
				x = CORDIC_GAIN;
				y = 0;
				for (int i = 0; i < CORDIC_STEPS; i++) begin
					dx = y >>> i;
					dy = x >>> i;
					if (z >= 0) begin
						x = x - dx;
						y = y + dy;
						z = z - atan_step[i];
					end else begin
						x = x + dx;
						y = y - dy;
						z = z + atan_step[i];
					end
				end
				if (flip) begin
					x = -x;
					y = -y;
				end
				q = (beta * x - ia * y) >>> PROD_SHIFT;
				if (q > IQ_MAX)
					q = IQ_MAX;
				if (q < IQ_MIN)
					q = IQ_MIN;
			end
			r.iq = IQ_W'(q);
			r.calibrated = offsets_valid;
			iq_due.push_back(r);
		endfunction

		function void match_result(logic signed [IQ_W-1:0] iq, logic calibrated);
			iq_result_t want;
			if (iq_due.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: result with nothing due: iq=%0d calibrated=%b",
						$time, iq, calibrated);
				return;
			end
			want = iq_due.pop_front();
			if (iq !== want.iq || calibrated !== want.calibrated) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: iq expected %0d got %0d, calibrated expected %b got %b",
						$time, want.iq, iq, want.calibrated, calibrated);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   steady;
	bit   timed_out;

	foc_iq_in_if  sample_ch ();
	foc_iq_out_if result_ch ();
	foc_iq_cfg_if cfg_ch ();

	q_current_board board = new();

	foc_current_to_iq_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop: the slowest legal run is well inside this.
	initial begin
		#RUN_LIMIT;
		$display("** foc_current_to_iq_unit: FAILED **");
		$finish;
	end

	// Mostly no gap, often a short one, now and then a long one; none in a steady stretch.
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one sample from a falling edge, hold it until the transfer, return on the next
	// falling edge with valid still high, so back-to-back samples never drop valid.
	task automatic send_sample(sample_t s);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid   = 1'b1;
		sample_ch.command = s.command;
		sample_ch.adc_a   = s.adc_a;
		sample_ch.adc_b   = s.adc_b;
		sample_ch.angle   = s.angle;
		do @(posedge clk); while (!sample_ch.ready);
		board.accept_sample(s);
		@(negedge clk);
	endtask

	// Write the scale only once every result due has come back and no sample is on offer.
	task automatic write_scale(logic [SCALE_W-1:0] value);
		sample_ch.valid = 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		cfg_ch.valid         = 1'b1;
		cfg_ch.current_scale = value;
		do @(posedge clk); while (!cfg_ch.ready);
		board.amps_per_count = value;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Calibration samples sit near mid-scale as a quiet phase current would, with some
	// spread over the full range; measure samples cover the full range with any angle.
	function automatic sample_t random_sample();
		sample_t s;
		s.command = ($urandom_range(0, 99) < 75) ? CMD_CALIBRATE : CMD_MEASURE;
		s.angle   = ANGLE_FIELD_W'($urandom_range(0, 4095));
		if ($urandom_range(0, 99) < 70) begin
			s.adc_a = (s.command == CMD_CALIBRATE) ? ADC_FIELD_W'(1984 + $urandom_range(0, 128))
				: ADC_FIELD_W'(1024 + $urandom_range(0, 2047));
			s.adc_b = (s.command == CMD_CALIBRATE) ? ADC_FIELD_W'(1984 + $urandom_range(0, 128))
				: ADC_FIELD_W'(1024 + $urandom_range(0, 2047));
		end else begin
			s.adc_a = ADC_FIELD_W'($urandom_range(0, 4095));
			s.adc_b = ADC_FIELD_W'($urandom_range(0, 4095));
		end
		return s;
	endfunction

	// Receiver: accept freely, stall now and then, mostly briefly; never in a steady stretch.
	initial begin : drain_side
		int stall_left;
		stall_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0 && !steady) begin
				result_ch.ready = 1'b0;
				stall_left--;
			end else begin
				result_ch.ready = 1'b1;
				stall_left = 0;
				if (!steady && $urandom_range(0, 99) < 20)
					stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
						: $urandom_range(1, 3);
			end
		end
	end

	// Check every result transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready)
			board.match_result(result_ch.iq, result_ch.calibrated);
	end

	initial begin : stimulus
		sample_t                  directed[$];
		logic [SCALE_W-1:0] scale_plan[PHASES];

		// Hold every input at a known level from time zero.
		arst_n               = 1'b0;
		steady               = 1'b0;
		timed_out            = 1'b0;
		sample_ch.valid      = 1'b0;
		sample_ch.command    = CMD_CALIBRATE;
		sample_ch.adc_a      = '0;
		sample_ch.adc_b      = '0;
		sample_ch.angle      = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.current_scale = SCALE_RESET;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset scale with zero offsets: corner counts, each quadrant
		// and the fold at +-90 degrees, then calibration samples at the count extremes, and one last measure sample.
		directed = '{
			'{CMD_MEASURE, 12'd4095, 12'd4095, 12'd0},
			'{CMD_MEASURE, 12'd0,    12'd0,    12'd0},
			'{CMD_MEASURE, 12'd0,    12'd4095, 12'd1024},
			'{CMD_MEASURE, 12'd4095, 12'd0,    12'd1024},
			'{CMD_MEASURE, 12'd2048, 12'd2048, 12'd2048},
			'{CMD_MEASURE, 12'd4095, 12'd0,    12'd3072},
			'{CMD_MEASURE, 12'd0,    12'd4095, 12'd4095},
			'{CMD_MEASURE, 12'd4095, 12'd4095, 12'd1},
			'{CMD_MEASURE, 12'd0,    12'd0,    12'd2047},
			'{CMD_MEASURE, 12'd4095, 12'd0,    12'd2049},
			'{CMD_MEASURE, 12'd0,    12'd4095, 12'd1025},
			'{CMD_MEASURE, 12'd0,    12'd4095, 12'd3071},
			'{CMD_MEASURE, 12'd4095, 12'd0,    12'd3073},
			'{CMD_MEASURE, 12'd1234, 12'd3000, 12'd512},
			'{CMD_CALIBRATE, 12'd0,    12'd0,    12'd0},
			'{CMD_CALIBRATE, 12'd4095, 12'd4095, 12'd4095},
			'{CMD_CALIBRATE, 12'd4095, 12'd0,    12'd2730},
			'{CMD_MEASURE, 12'd2730, 12'd1365, 12'd2730}
		};
		foreach (directed[k])
			send_sample(directed[k]);

		// One scale per phase: both extremes, the smallest step, unity and two random ones.
		// A calibration run straddles phases, so its offsets are built up across scale
		// changes and then applied to the measure samples that follow.
		scale_plan[0] = {SCALE_W{1'b1}};
		scale_plan[1] = '0;
		scale_plan[2] = SCALE_W'(1);
		scale_plan[3] = SCALE_W'($urandom_range(0, (1 << SCALE_W) - 1));
		scale_plan[4] = SCALE_RESET;
		scale_plan[5] = SCALE_W'($urandom_range(1, 24'h03FFFF));

		for (int p = 0; p < PHASES; p++) begin
			write_scale(scale_plan[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Drop in and out of stretches with no idling on either side.
				if ($urandom_range(0, 99) == 0)
					steady = !steady;
				send_sample(random_sample());
			end
		end
		sample_ch.valid = 1'b0;
		steady = 1'b0;

		// Drain: wait for every result due, then a few more cycles for strays.
		while (board.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0 && !timed_out)
			$display("** foc_current_to_iq_unit: PASSED **");
		else
			$display("** foc_current_to_iq_unit: FAILED **");
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/foc_iq_pkg.sv
hw/rtl/foc_iq_if.sv
hw/rtl/foc_iq_cordic.sv
hw/rtl/foc_current_to_iq_unit.sv
sim/foc_current_to_iq_unit_test.sv
